### design/afr_pkg.sv
// ============================================================================
// afr_pkg
// Shared constants and types of the addressed frame receiver.
// ============================================================================
`default_nettype none

package afr_pkg;

    localparam int unsigned DEFAULT_PAYLOAD_DEPTH = 64;

    localparam logic [7:0] START_BYTE = 8'h24;
    localparam logic [7:0] END_BYTE   = 8'h23;

    // Handover from the parser to the delivery side when a frame closes.
    typedef struct packed {
        logic start;
        logic ok;
    } deliver_ctrl_t;

endpackage

`default_nettype wire

### design/afr_parser.sv
// ============================================================================
// afr_parser
// Byte-level frame parser: start, address, length, payload, checksum, end.
// ============================================================================
`default_nettype none

module afr_parser
    import afr_pkg::*;
#(
    parameter int unsigned PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH,
    localparam int unsigned LEN_W  = $clog2(PAYLOAD_DEPTH + 1),
    localparam int unsigned ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_accept,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [15:0]       own_address,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [7:0]             wr_data,
    output deliver_ctrl_t          deliver,
    output logic [LEN_W-1:0]       deliver_len
);

    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_ADDR = 6'b000010,
        PH_LEN  = 6'b000100,
        PH_DATA = 6'b001000,
        PH_CHK  = 6'b010000,
        PH_END  = 6'b100000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             low_seen_reg, low_seen_next;
    logic [7:0]       low_byte_reg, low_byte_next;
    logic [7:0]       sum_reg, sum_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             match_reg, match_next;

    always_comb
    begin
        phase_next    = phase_reg;
        low_seen_next = low_seen_reg;
        low_byte_next = low_byte_reg;
        sum_next      = sum_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        match_next    = match_reg;
        wr_en         = 1'b0;
        deliver.start = 1'b0;
        deliver.ok    = match_reg;
        if (byte_accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        low_seen_next = 1'b0;
                        sum_next      = '0;
                        count_next    = '0;
                        phase_next    = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    sum_next = sum_reg + rx_byte;
                    if (!low_seen_reg)
                    begin
                        low_byte_next = rx_byte;
                        low_seen_next = 1'b1;
                    end
                    else if ({rx_byte, low_byte_reg} == own_address)
                    begin
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_LEN:
                begin
                    if (rx_byte > 8'(PAYLOAD_DEPTH))
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        len_next   = LEN_W'(rx_byte);
                        sum_next   = sum_reg + rx_byte;
                        phase_next = (rx_byte == 8'd0) ? PH_CHK : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    // Length is never zero and never above the depth here.
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + rx_byte;
                    if (count_next == len_reg)
                    begin
                        phase_next = PH_CHK;
                    end
                end
                PH_CHK:
                begin
                    match_next = (rx_byte == sum_reg);
                    phase_next = PH_END;
                end
                PH_END:
                begin
                    if (rx_byte == END_BYTE)
                    begin
                        deliver.start = 1'b1;
                        phase_next    = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    assign wr_addr     = count_reg[ADDR_W-1:0];
    assign wr_data     = rx_byte;
    assign deliver_len = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            low_seen_reg <= 1'b0;
            low_byte_reg <= '0;
            sum_reg      <= '0;
            len_reg      <= '0;
            count_reg    <= '0;
            match_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            low_seen_reg <= low_seen_next;
            low_byte_reg <= low_byte_next;
            sum_reg      <= sum_next;
            len_reg      <= len_next;
            count_reg    <= count_next;
            match_reg    <= match_next;
        end
    end

endmodule

`default_nettype wire

### design/afr_buffer.sv
// ============================================================================
// afr_buffer
// Payload memory and the read-out burst that delivers a completed frame.
// ============================================================================
`default_nettype none

module afr_buffer
    import afr_pkg::*;
#(
    parameter int unsigned PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH,
    localparam int unsigned LEN_W  = $clog2(PAYLOAD_DEPTH + 1),
    localparam int unsigned ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire deliver_ctrl_t     deliver,
    input  wire logic [LEN_W-1:0]  deliver_len,
    output logic                   busy,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             payload_byte,
    output logic                   last,
    output logic                   checksum_ok,
    output logic                   empty_frame
);

    logic [7:0] mem [PAYLOAD_DEPTH];
    logic [7:0] mem_q_reg;

    logic             burst_reg;
    logic [LEN_W-1:0] rd_idx_reg;
    logic [LEN_W-1:0] len_reg;
    logic             empty_reg;
    logic             ok_reg;

    logic p1_valid_reg, p1_last_reg, p1_empty_reg, p1_ok_reg;
    logic out_valid_reg, out_last_reg, out_ok_reg, out_empty_reg;
    logic [7:0] out_byte_reg;

    logic             out_load;
    logic             issue;
    logic             issue_last;
    logic [LEN_W-1:0] rd_idx_inc;

    assign out_load   = p1_valid_reg && (!out_valid_reg || out_ready);
    assign issue      = burst_reg && (!p1_valid_reg || out_load);
    assign rd_idx_inc = rd_idx_reg + 1'b1;
    assign issue_last = empty_reg || (rd_idx_inc == len_reg);

    // Writes happen only while no burst runs, so they never meet a read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            mem_q_reg <= mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg     <= 1'b0;
            rd_idx_reg    <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (deliver.start)
            begin
                burst_reg  <= 1'b1;
                rd_idx_reg <= '0;
            end
            else if (issue)
            begin
                rd_idx_reg <= rd_idx_inc;
                if (issue_last)
                begin
                    burst_reg <= 1'b0;
                end
            end

            if (issue)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                p1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (deliver.start)
        begin
            len_reg   <= deliver_len;
            empty_reg <= (deliver_len == '0);
            ok_reg    <= deliver.ok;
        end
        if (issue)
        begin
            p1_last_reg  <= issue_last;
            p1_empty_reg <= empty_reg;
            p1_ok_reg    <= ok_reg;
        end
        if (out_load)
        begin
            out_byte_reg  <= p1_empty_reg ? 8'd0 : mem_q_reg;
            out_last_reg  <= p1_last_reg;
            out_ok_reg    <= p1_ok_reg;
            out_empty_reg <= p1_empty_reg;
        end
    end

    assign busy         = burst_reg;
    assign out_valid    = out_valid_reg;
    assign payload_byte = out_byte_reg;
    assign last         = out_last_reg;
    assign checksum_ok  = out_ok_reg;
    assign empty_frame  = out_empty_reg;

endmodule

`default_nettype wire

### design/addressed_frame_receiver_core.sv
// After the closing '#' the first word passes the burst flag, read and output registers.
// Throughput: one received byte per cycle while parsing; the delivery burst then reads
// one payload word per cycle unless out_ready stalls it; no byte is accepted meanwhile.
// Reset: rst_n clears the parser, the burst reader and the output register at once;
// the payload memory is not cleared and needs no clearing pass.
// ============================================================================
// addressed_frame_receiver_core
// Frame receiver that checks address and checksum and replays the payload.
// ============================================================================
`default_nettype none

module addressed_frame_receiver_core
    import afr_pkg::*;
#(
    parameter int unsigned PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] own_address,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       payload_byte,
    output logic             last,
    output logic             checksum_ok,
    output logic             empty_frame
);

    localparam int unsigned LEN_W  = $clog2(PAYLOAD_DEPTH + 1);
    localparam int unsigned ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    logic [15:0]       own_address_reg;
    logic              busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    deliver_ctrl_t     deliver;
    logic [LEN_W-1:0]  deliver_len;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
        end
        else if (cfg_valid)
        begin
            own_address_reg <= own_address;
        end
    end

    afr_parser #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (in_valid && in_ready),
        .rx_byte     (rx_byte),
        .own_address (own_address_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .deliver     (deliver),
        .deliver_len (deliver_len)
    );

    afr_buffer #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_buffer (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .deliver      (deliver),
        .deliver_len  (deliver_len),
        .busy         (busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .payload_byte (payload_byte),
        .last         (last),
        .checksum_ok  (checksum_ok),
        .empty_frame  (empty_frame)
    );

endmodule

`default_nettype wire

### design/afr_checker.sv
// ============================================================================
// afr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ============================================================================
`default_nettype none

module afr_checker
    import afr_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] rx_byte,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] payload_byte,
    input wire logic       last,
    input wire logic       empty_frame
);

    // An empty frame is a single word, so it must close its frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_frame |-> last)
        else $error("empty frame word without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_frame |-> payload_byte == 8'd0)
        else $error("empty frame word carries a non-zero byte");

    // Input is only held off once a closing byte has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && rx_byte != END_BYTE |=> in_ready)
        else $error("input stalled without a closing byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(last))
        else $error("stalled output word changed");

endmodule

bind addressed_frame_receiver_core afr_checker u_afr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .last         (last),
    .empty_frame  (empty_frame)
);

`default_nettype wire
